@@ design/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
package tcw_pkg;

	localparam int MODE_W = 2;
	localparam int CHAR_W = 8;
	localparam int CADDR_W = 11;
	localparam int CELL_W = 16;
	localparam int ATTR_W = 8;

	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUT = 2'd0,
		MODE_READ = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_READ_WAIT,
		ST_SCROLL_RD,
		ST_SCROLL_WR,
		ST_FILL,
		ST_RESP
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic put;
		logic read_issue;
		logic read_capture;
		logic ptr_clear;
		logic scroll_rd;
		logic scroll_wr;
		logic fill;
		logic home;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic need_scroll;
		logic addr_ok;
		logic copy_last;
		logic fill_last;
	} dp_status_t;

endpackage

@@ design/tcw_datapath.sv @@
// Datapath of the text console writer: screen memory, cursor, item and result registers.
module tcw_datapath #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  logic clk,
	input  logic arst_n,
	input  tcw_pkg::dp_cmd_t cmd,
	output tcw_pkg::dp_status_t status,
	input  logic [tcw_pkg::MODE_W-1:0] in_mode,
	input  logic [tcw_pkg::CHAR_W-1:0] in_char,
	input  logic [tcw_pkg::CADDR_W-1:0] in_addr,
	input  logic cfg_wen,
	input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata,
	output logic [tcw_pkg::CADDR_W-1:0] cursor_address,
	output logic [tcw_pkg::CELL_W-1:0] read_data
);
	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW = $clog2(CELLS);
	localparam int CW = $clog2(COLUMNS);
	localparam int RW = $clog2(ROWS);
	localparam int LAST_BASE = CELLS - COLUMNS;

	logic [MODE_W-1:0] mode_q;
	logic [CHAR_W-1:0] char_q;
	logic [CADDR_W-1:0] caddr_q;
	logic [ATTR_W-1:0] attr_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] cur_q;
	logic [AW-1:0] ptr_q;
	logic [CELL_W-1:0] rdata_q;
	logic [CELL_W-1:0] result_q;
	logic [CADDR_W-1:0] out_cursor_q;
	logic [CELL_W-1:0] out_data_q;
	logic [CELL_W-1:0] mem [CELLS];

	logic is_nl;
	logic next_row;
	logic last_row;
	logic we;
	logic re;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [CELL_W-1:0] wdata;

	assign is_nl = (char_q == NEWLINE_CODE);
	assign next_row = is_nl || (col_q == CW'(COLUMNS - 1));
	assign last_row = (row_q == RW'(ROWS - 1));

	assign status.mode = mode_q;
	assign status.need_scroll = next_row && last_row;
	assign status.addr_ok = ({21'b0, caddr_q} < 32'(CELLS));
	assign status.copy_last = (ptr_q == AW'(LAST_BASE - 1));
	assign status.fill_last = (ptr_q == AW'(CELLS - 1));

	assign we = (cmd.put && !is_nl) || cmd.scroll_wr || cmd.fill;
	assign waddr = cmd.put ? cur_q : ptr_q;
	assign wdata = cmd.put ? {attr_q, char_q} : (cmd.scroll_wr ? rdata_q : BLANK_CELL);
	assign re = cmd.read_issue || cmd.scroll_rd;
	assign raddr = cmd.scroll_rd ? AW'(ptr_q + AW'(COLUMNS)) : AW'(caddr_q);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= in_mode;
			char_q <= in_char;
			caddr_q <= in_addr;
		end
		if (cmd.accept) begin
			result_q <= '0;
		end else if (cmd.read_capture) begin
			result_q <= rdata_q;
		end
		if (cmd.load_out) begin
			out_cursor_q <= CADDR_W'(cur_q);
			out_data_q <= result_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_wen) begin
			attr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cur_q <= '0;
		end else if (cmd.home) begin
			col_q <= '0;
			row_q <= '0;
			cur_q <= '0;
		end else if (cmd.put) begin
			if (next_row) begin
				col_q <= '0;
				if (last_row) begin
					cur_q <= AW'(LAST_BASE);
				end else begin
					row_q <= RW'(row_q + RW'(1));
					cur_q <= AW'(cur_q - AW'(col_q) + AW'(COLUMNS));
				end
			end else begin
				col_q <= CW'(col_q + CW'(1));
				cur_q <= AW'(cur_q + AW'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.ptr_clear) begin
			ptr_q <= '0;
		end else if (cmd.scroll_wr || cmd.fill) begin
			ptr_q <= AW'(ptr_q + AW'(1));
		end
	end

	assign cursor_address = out_cursor_q;
	assign read_data = out_data_q;

endmodule

@@ design/tcw_ctrl.sv @@
// Controller state machine of the text console writer.
module tcw_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  tcw_pkg::dp_status_t status,
	output tcw_pkg::dp_cmd_t cmd
);
	import tcw_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (status.fill_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (status.mode)
					MODE_PUT: state_d = status.need_scroll ? ST_SCROLL_RD : ST_RESP;
					MODE_READ: state_d = status.addr_ok ? ST_READ_WAIT : ST_RESP;
					MODE_CLEAR: state_d = ST_FILL;
					default: state_d = ST_RESP;
				endcase
			end
			ST_READ_WAIT: state_d = ST_RESP;
			ST_SCROLL_RD: state_d = ST_SCROLL_WR;
			ST_SCROLL_WR: state_d = status.copy_last ? ST_FILL : ST_SCROLL_RD;
			ST_FILL: begin
				if (status.fill_last) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_INIT: cmd.fill = 1'b1;
			ST_IDLE: cmd.accept = s_tvalid;
			ST_DECODE: begin
				unique case (status.mode)
					MODE_PUT: begin
						cmd.put = 1'b1;
						cmd.ptr_clear = 1'b1;
					end
					MODE_READ: cmd.read_issue = status.addr_ok;
					MODE_CLEAR: begin
						cmd.home = 1'b1;
						cmd.ptr_clear = 1'b1;
					end
					default: cmd = '0;
				endcase
			end
			ST_READ_WAIT: cmd.read_capture = 1'b1;
			ST_SCROLL_RD: cmd.scroll_rd = 1'b1;
			ST_SCROLL_WR: cmd.scroll_wr = 1'b1;
			ST_FILL: cmd.fill = 1'b1;
			ST_RESP: cmd.load_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ design/text_console_writer_core.sv @@
// Top level of the text console writer: stream ports, configuration port and submodules.
// The block keeps a COLUMNS x ROWS screen of 16-bit cells (attribute high, character low)
// in a single-port-write, single-port-read memory, and takes one request at a time. A
// cell read within the screen goes through the registered memory read. A put or newline
// that moves past the bottom row scrolls the screen by copying each cell below the top
// row up one row through the memory, with a read and then a write per cell, and then
// blanking the bottom row; a clear blanks the whole screen. After reset the block blanks
// the memory before it accepts its first request; the attribute register can be written
// during that time.
module text_console_writer_core #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [23:0] s_tdata,    // char_code[7:0], cell_address[18:8], zero fill
	input  logic [1:0] s_tuser,     // mode[1:0]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [31:0] m_tdata,    // cursor_address[10:0], read_data[26:11], zero fill
	input  logic cfg_wen,
	input  logic [7:0] cfg_wdata    // text_attribute
);
	import tcw_pkg::*;

	dp_cmd_t cmd;
	dp_status_t status;
	logic [CADDR_W-1:0] cursor_address;
	logic [CELL_W-1:0] read_data;

	tcw_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.status(status),
		.cmd(cmd)
	);

	tcw_datapath #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.in_mode(s_tuser),
		.in_char(s_tdata[7:0]),
		.in_addr(s_tdata[18:8]),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.cursor_address(cursor_address),
		.read_data(read_data)
	);

	assign m_tdata = {5'b0, read_data, cursor_address};

endmodule
